@@ rtl/arpc_pkg.sv @@
package arpc_pkg;

    localparam int ENTRIES  = 16;
    localparam int SLOT_W   = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int QDEPTH   = 2;

    localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] IP_BCAST  = 32'hFFFF_FFFF;

    localparam logic [7:0] ENTRY_LIFE_RST    = 8'd20;
    localparam logic [7:0] REFRESH_LEVEL_RST = 8'd10;

    localparam logic [1:0] REG_OWN_MAC    = 2'd0;
    localparam logic [1:0] REG_LOCAL_IP   = 2'd1;
    localparam logic [1:0] REG_ENTRY_LIFE = 2'd2;
    localparam logic [1:0] REG_REFRESH    = 2'd3;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_REQ    = 2'd1;
    localparam logic [1:0] KIND_REPLY  = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_RESOLVE,
        OP_BCAST,
        OP_REQ_US,
        OP_REPLY,
        OP_TICK,
        OP_DEL_ONE,
        OP_DEL_ALL
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] peer_ip;
        logic [31:0] host_ip;
        logic [47:0] peer_mac;
    } cmd_t;

endpackage

@@ rtl/arpc_front.sv @@
module arpc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          mode,
    input  logic [31:0]         peer_ip,
    input  logic [31:0]         host_ip,
    input  logic [47:0]         peer_mac,
    input  logic [31:0]         local_ip,
    output logic                q_valid,
    input  logic                q_pop,
    output arpc_pkg::cmd_t      q_cmd
);

    arpc_pkg::cmd_t q_mem [arpc_pkg::QDEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    arpc_pkg::cmd_t cls;
    logic           push;

    always_comb
    begin
        cls.peer_ip  = peer_ip;
        cls.host_ip  = host_ip;
        cls.peer_mac = peer_mac;
        unique case (mode)
            3'd0:    cls.op = (peer_ip == arpc_pkg::IP_BCAST) ? arpc_pkg::OP_BCAST
                                                              : arpc_pkg::OP_RESOLVE;
            3'd1:    cls.op = (host_ip == local_ip) ? arpc_pkg::OP_REQ_US : arpc_pkg::OP_NONE;
            3'd2:    cls.op = (peer_ip != 32'd0 && peer_ip != arpc_pkg::IP_BCAST &&
                               peer_mac != arpc_pkg::MAC_BCAST) ? arpc_pkg::OP_REPLY
                                                                : arpc_pkg::OP_NONE;
            3'd3:    cls.op = arpc_pkg::OP_TICK;
            3'd4:    cls.op = (peer_ip == 32'd0) ? arpc_pkg::OP_DEL_ALL : arpc_pkg::OP_DEL_ONE;
            default: cls.op = arpc_pkg::OP_NONE;
        endcase
    end

    assign in_ready = (cnt_reg != 2'(arpc_pkg::QDEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(arpc_pkg::QDEPTH))
        else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'(arpc_pkg::QDEPTH)) |-> !in_ready)
        else $error("full queue accepts");

endmodule

@@ rtl/arpc_back.sv @@
module arpc_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  arpc_pkg::cmd_t      q_cmd,
    input  logic [7:0]          entry_life,
    input  logic [7:0]          refresh_level,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          kind,
    output logic                found,
    output logic [47:0]         mac_value,
    output logic [31:0]         target_ip,
    output logic [31:0]         sender_ip,
    output logic                last
);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ACT, S_TICK, S_EMIT, S_STATUS} state_t;

    localparam int SW = arpc_pkg::SLOT_W;
    localparam int CW = arpc_pkg::CNT_W;

    logic [arpc_pkg::ENTRIES-1:0] valid_reg;
    logic [31:0] pip_mem  [arpc_pkg::ENTRIES];
    logic [31:0] hip_mem  [arpc_pkg::ENTRIES];
    logic [47:0] mac_mem  [arpc_pkg::ENTRIES];
    logic        dyn_mem  [arpc_pkg::ENTRIES];
    logic        stb_mem  [arpc_pkg::ENTRIES];
    logic [7:0]  life_mem [arpc_pkg::ENTRIES];

    state_t         state_reg;
    arpc_pkg::cmd_t cmd_reg;
    logic [CW-1:0]  idx_reg;
    logic           hit_reg;
    logic [SW-1:0]  hit_slot_reg;
    logic           free_reg;
    logic [SW-1:0]  free_slot_reg;
    logic           found_reg;
    logic [47:0]    smac_reg;
    logic           emit_tick_reg;

    logic [SW-1:0]  idx;
    logic           out_free;
    logic           tick_refresh;
    logic           out_load;

    assign idx      = idx_reg[SW-1:0];
    assign out_free = !out_valid || out_ready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;

    // The slot under the tick walk is due for a refresh request.
    assign tick_refresh = valid_reg[idx] && life_mem[idx] != 8'd0 &&
                          life_mem[idx] <= refresh_level;
    // A new beat goes into the output register this cycle.
    assign out_load = out_free && ((state_reg == S_EMIT) || (state_reg == S_STATUS) ||
                                   (state_reg == S_TICK && tick_refresh));

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ACT && cmd_reg.op == arpc_pkg::OP_RESOLVE && !hit_reg && free_reg)
        begin
            pip_mem[free_slot_reg]  <= cmd_reg.peer_ip;
            hip_mem[free_slot_reg]  <= cmd_reg.host_ip;
            mac_mem[free_slot_reg]  <= 48'd0;
            dyn_mem[free_slot_reg]  <= 1'b1;
            stb_mem[free_slot_reg]  <= 1'b0;
            life_mem[free_slot_reg] <= refresh_level;
        end
        else if (state_reg == S_ACT && cmd_reg.op == arpc_pkg::OP_REPLY && hit_reg &&
                 dyn_mem[hit_slot_reg])
        begin
            mac_mem[hit_slot_reg]  <= cmd_reg.peer_mac;
            stb_mem[hit_slot_reg]  <= 1'b1;
            life_mem[hit_slot_reg] <= entry_life;
        end
        else if (state_reg == S_TICK && valid_reg[idx] && life_mem[idx] != 8'd0 &&
                 (life_mem[idx] <= refresh_level || dyn_mem[idx]) &&
                 (out_free || life_mem[idx] > refresh_level))
        begin
            life_mem[idx] <= life_mem[idx] - 8'd1;
        end
    end

    // Search and aging check one slot per cycle; a refresh wait pauses aging.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid     <= 1'b0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            found_reg     <= 1'b0;
            emit_tick_reg <= 1'b0;
            cmd_reg       <= '0;
            hit_slot_reg  <= '0;
            free_slot_reg <= '0;
            smac_reg      <= '0;
            kind          <= arpc_pkg::KIND_STATUS;
            found         <= 1'b0;
            mac_value     <= '0;
            target_ip     <= '0;
            sender_ip     <= '0;
            last          <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid <= 1'b1;
            end
            else if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            emit_tick_reg <= (state_reg == S_TICK) && tick_refresh && out_free;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg   <= q_cmd;
                        idx_reg   <= '0;
                        hit_reg   <= 1'b0;
                        free_reg  <= 1'b0;
                        found_reg <= 1'b0;
                        smac_reg  <= '0;
                        unique case (q_cmd.op)
                            arpc_pkg::OP_RESOLVE, arpc_pkg::OP_REPLY, arpc_pkg::OP_DEL_ONE:
                                state_reg <= S_SCAN;
                            arpc_pkg::OP_TICK:
                                state_reg <= S_TICK;
                            default:
                                state_reg <= S_ACT;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (!hit_reg && valid_reg[idx] && pip_mem[idx] == cmd_reg.peer_ip)
                    begin
                        hit_reg      <= 1'b1;
                        hit_slot_reg <= idx;
                    end
                    if (!free_reg && !valid_reg[idx])
                    begin
                        free_reg      <= 1'b1;
                        free_slot_reg <= idx;
                    end
                    if (idx_reg == CW'(arpc_pkg::ENTRIES - 1))
                    begin
                        state_reg <= S_ACT;
                    end
                    idx_reg <= idx_reg + CW'(1);
                end
                S_ACT:
                begin
                    state_reg <= S_STATUS;
                    unique case (cmd_reg.op)
                        arpc_pkg::OP_BCAST:
                        begin
                            found_reg <= 1'b1;
                            smac_reg  <= arpc_pkg::MAC_BCAST;
                        end
                        arpc_pkg::OP_RESOLVE:
                        begin
                            if (hit_reg && stb_mem[hit_slot_reg])
                            begin
                                found_reg <= 1'b1;
                                smac_reg  <= mac_mem[hit_slot_reg];
                            end
                            else if (hit_reg || free_reg)
                            begin
                                if (!hit_reg)
                                begin
                                    valid_reg[free_slot_reg] <= 1'b1;
                                end
                                state_reg <= S_EMIT;
                            end
                        end
                        arpc_pkg::OP_REQ_US:
                            state_reg <= S_EMIT;
                        arpc_pkg::OP_REPLY:
                            found_reg <= hit_reg && dyn_mem[hit_slot_reg];
                        arpc_pkg::OP_DEL_ONE:
                        begin
                            if (hit_reg)
                            begin
                                valid_reg[hit_slot_reg] <= 1'b0;
                                found_reg <= 1'b1;
                            end
                        end
                        arpc_pkg::OP_DEL_ALL:
                        begin
                            valid_reg <= '0;
                            found_reg <= 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        found     <= 1'b0;
                        last      <= 1'b0;
                        target_ip <= cmd_reg.peer_ip;
                        sender_ip <= cmd_reg.host_ip;
                        if (cmd_reg.op == arpc_pkg::OP_REQ_US)
                        begin
                            kind      <= arpc_pkg::KIND_REPLY;
                            mac_value <= cmd_reg.peer_mac;
                        end
                        else
                        begin
                            kind      <= arpc_pkg::KIND_REQ;
                            mac_value <= arpc_pkg::MAC_BCAST;
                        end
                        state_reg <= S_STATUS;
                    end
                end
                S_TICK:
                begin
                    // A refresh request waits for room in the output register.
                    if (!valid_reg[idx] || life_mem[idx] > refresh_level ||
                        life_mem[idx] == 8'd0 || out_free)
                    begin
                        if (valid_reg[idx] && life_mem[idx] == 8'd0)
                        begin
                            valid_reg[idx] <= 1'b0;
                        end
                        else if (valid_reg[idx] && life_mem[idx] <= refresh_level)
                        begin
                            kind      <= arpc_pkg::KIND_REQ;
                            found     <= 1'b0;
                            mac_value <= arpc_pkg::MAC_BCAST;
                            target_ip <= pip_mem[idx];
                            sender_ip <= hip_mem[idx];
                            last      <= 1'b0;
                        end
                        if (idx_reg == CW'(arpc_pkg::ENTRIES - 1))
                        begin
                            state_reg <= S_STATUS;
                        end
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                S_STATUS:
                begin
                    if (out_free)
                    begin
                        kind      <= arpc_pkg::KIND_STATUS;
                        found     <= found_reg;
                        mac_value <= smac_reg;
                        target_ip <= '0;
                        sender_ip <= '0;
                        last      <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == arpc_pkg::KIND_STATUS) |-> last)
        else $error("status beat without last");
    a_frame_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != arpc_pkg::KIND_STATUS) |-> (!last && !found))
        else $error("frame beat marked last or found");
    a_tick_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit_tick_reg |-> out_valid)
        else $error("refresh request lost");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg != S_IDLE)
        else $error("popped command not taken");

endmodule

@@ rtl/arp_cache_engine.sv @@
// Channel   Direction  Handshake                Payload
// in        input      in_valid / in_ready      mode, peer_ip, host_ip, peer_mac
// out       output     out_valid / out_ready    kind, found, mac_value, target_ip,
//                                               sender_ip, last
// cfg       input      cfg_we (no wait)         cfg_index, cfg_data
//
// A beat enters a two-deep command queue in the cycle it is accepted. For a
// resolve, reply, single delete or tick, the back end then walks the sixteen
// slots one per cycle; a tick walk pauses while a refresh beat waits for the
// output register. Other events skip the walk. Each command ends in a status
// beat, which follows any request or reply beat that it sends.
// Reset is asynchronous and active low; it empties the queue and the table.
// Output stalls hold the back end only; the queue keeps taking input beats until it is full.
module arp_cache_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [31:0] peer_ip,
    input  logic [31:0] host_ip,
    input  logic [47:0] peer_mac,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic        found,
    output logic [47:0] mac_value,
    output logic [31:0] target_ip,
    output logic [31:0] sender_ip,
    output logic        last,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    // Configuration registers. The own MAC is held for software but no result
    // field carries it.
    logic [47:0] own_mac_reg;
    logic [31:0] local_ip_reg;
    logic [7:0]  entry_life_reg;
    logic [7:0]  refresh_level_reg;

    logic           q_valid;
    logic           q_pop;
    arpc_pkg::cmd_t q_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg       <= '0;
            local_ip_reg      <= '0;
            entry_life_reg    <= arpc_pkg::ENTRY_LIFE_RST;
            refresh_level_reg <= arpc_pkg::REFRESH_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                arpc_pkg::REG_OWN_MAC:    own_mac_reg       <= cfg_data;
                arpc_pkg::REG_LOCAL_IP:   local_ip_reg      <= cfg_data[31:0];
                arpc_pkg::REG_ENTRY_LIFE: entry_life_reg    <= cfg_data[7:0];
                arpc_pkg::REG_REFRESH:    refresh_level_reg <= cfg_data[7:0];
                default:                  own_mac_reg       <= own_mac_reg;
            endcase
        end
    end

    // The front end classifies each beat so the back end only sees operations.
    arpc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .peer_ip  (peer_ip),
        .host_ip  (host_ip),
        .peer_mac (peer_mac),
        .local_ip (local_ip_reg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd)
    );

    arpc_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_cmd         (q_cmd),
        .entry_life    (entry_life_reg),
        .refresh_level (refresh_level_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .found         (found),
        .mac_value     (mac_value),
        .target_ip     (target_ip),
        .sender_ip     (sender_ip),
        .last          (last)
    );

endmodule
